/* design/sssd_pkg.sv */
// Shared types, constants and the character font for the seven-segment string driver.
// No dependencies.
package sssd_pkg;

  localparam logic [7:0] DOT_CODE  = 8'h2E;
  localparam logic [7:0] END_CODE  = 8'h00;  // zero byte ends the message early
  localparam int         POS_W     = 3;   // held position, covers up to eight digits
  localparam int         QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [1:0] digit_position;
    logic [6:0] segment_mask;
    logic       point_lit;
    logic       last_digit;
  } out_word_t;

  // Words handed from the front to the queue in one cycle (zero, one or two).
  typedef struct packed {
    logic [1:0] count;
    out_word_t  first;
    out_word_t  second;
  } push_t;

  localparam logic [6:0] LETTER_FONT [26] = '{
    7'h77, 7'h7C, 7'h58, 7'h5E, 7'h79, 7'h71, 7'h3D, 7'h76, 7'h03, 7'h1F, 7'h76, 7'h38,
    7'h54, 7'h54, 7'h5C, 7'h73, 7'h00, 7'h50, 7'h6D, 7'h78, 7'h1C, 7'h1C, 7'h00, 7'h76,
    7'h6E, 7'h5B
  };

  localparam logic [6:0] DIGIT_FONT [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  // Upper-case letters other than Q and W, and decimal digits, have a glyph; everything else is blank.
  function automatic logic [6:0] glyph(input logic [7:0] code);
    logic [7:0] letter_off;
    logic [7:0] digit_off;
    letter_off = code - 8'h41;
    digit_off  = code - 8'h30;
    if (code inside {[8'h41:8'h5A]}) begin
      return LETTER_FONT[letter_off[4:0]];
    end else if (code inside {[8'h30:8'h39]}) begin
      return DIGIT_FONT[digit_off[3:0]];
    end else begin
      return 7'h00;
    end
  endfunction

endpackage

/* design/sssd_front.sv */
// Front end: accepts characters, keeps the one-digit lookahead and decides which
// digits are finished. Depends on sssd_pkg.
module sssd_front import sssd_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     space_ok,
  input  in_word_t in_word,
  output push_t    push
);

  logic             held_valid, held_valid_next;
  logic [6:0]       held_segments, held_segments_next;
  logic             held_point, held_point_next;
  logic [POS_W-1:0] next_position, next_position_next;
  logic             ignoring_rest, ignoring_rest_next;

  logic accept;
  logic final_pos;
  logic eom;

  assign accept    = in_valid && space_ok;
  assign eom       = in_word.end_of_message;
  assign final_pos = ({1'b0, next_position} + 4'd1) >= 4'(DIGIT_COUNT);

  always_comb begin
    out_word_t w;
    logic [1:0] n;
    out_word_t  w0, w1;
    logic       put_new;
    held_valid_next    = held_valid;
    held_segments_next = held_segments;
    held_point_next    = held_point;
    next_position_next = next_position;
    ignoring_rest_next = ignoring_rest;
    n  = 2'd0;
    w  = '0;
    w0 = '0;
    w1 = '0;
    put_new = 1'b0;

    w.digit_position = next_position[1:0];
    w.segment_mask   = held_segments;
    w.point_lit      = held_point;
    w.last_digit     = 1'b1;

    if (ignoring_rest) begin
      // drop
    end else if (in_word.char_code == END_CODE) begin
      if (held_valid) begin
        n  = 2'd1;
        w0 = w;
      end
      held_valid_next    = 1'b0;
      ignoring_rest_next = 1'b1;
    end else if (held_valid && !held_point && in_word.char_code == DOT_CODE) begin
      held_point_next = 1'b1;
      if (eom || final_pos) begin
        n  = 2'd1;
        w0 = w;
        w0.point_lit       = 1'b1;
        held_valid_next    = 1'b0;
        ignoring_rest_next = 1'b1;
      end
    end else begin
      if (held_valid) begin
        n  = 2'd1;
        w0 = w;
        w0.last_digit = final_pos;
        if (final_pos) begin
          ignoring_rest_next = 1'b1;
        end else begin
          next_position_next = next_position + 1'b1;
        end
      end
      if (!(held_valid && final_pos)) begin
        put_new            = 1'b1;
        held_valid_next    = 1'b1;
        held_segments_next = glyph(in_word.char_code);
        held_point_next    = 1'b0;
      end else begin
        held_valid_next = 1'b0;
      end
      if (put_new && eom) begin
        held_valid_next = 1'b0;
        w1.digit_position = next_position_next[1:0];
        w1.segment_mask   = held_segments_next;
        w1.point_lit      = 1'b0;
        w1.last_digit     = 1'b1;
        if (n == 2'd1) begin
          n = 2'd2;
        end else begin
          n  = 2'd1;
          w0 = w1;
          w1 = '0;
        end
      end
    end

    if (eom) begin
      held_valid_next    = 1'b0;
      held_segments_next = 7'h00;
      held_point_next    = 1'b0;
      next_position_next = '0;
      ignoring_rest_next = 1'b0;
    end

    push.count  = accept ? n : 2'd0;
    push.first  = w0;
    push.second = w1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid    <= 1'b0;
      held_segments <= 7'h00;
      held_point    <= 1'b0;
      next_position <= '0;
      ignoring_rest <= 1'b0;
    end else if (accept) begin
      held_valid    <= held_valid_next;
      held_segments <= held_segments_next;
      held_point    <= held_point_next;
      next_position <= next_position_next;
      ignoring_rest <= ignoring_rest_next;
    end
  end

`ifndef SYNTHESIS
  // second digit of a character only comes from an end of message, after a non-final one
  a_two_words: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.second.last_digit && !push.first.last_digit)
    else $error("two-digit push with wrong last flags");

  a_eom_restart: assert property (@(posedge clk) disable iff (rst)
    accept && in_word.end_of_message |=> !held_valid && next_position == '0 && !ignoring_rest)
    else $error("state not restarted after end of message");

  a_ignore_empty: assert property (@(posedge clk) disable iff (rst)
    ignoring_rest |-> !held_valid)
    else $error("digit held while dropping bytes");
`endif

endmodule

/* design/sssd_queue.sv */
// Back end: four-entry queue of finished digits that also drives the output channel.
// Depends on sssd_pkg.
module sssd_queue import sssd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  push_t     push,
  output logic      space_ok,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  out_word_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign out_valid = count != '0;
  assign out_word  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  // room for the worst case of two digits from one character
  assign space_ok  = count <= CNT_W'(QUEUE_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + 1'b1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(push.count) <= CNT_W'(QUEUE_DEPTH) - count)
    else $error("queue overflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    pop && push.count == 2'd0 |=> count == $past(count) - 1'b1)
    else $error("queue count wrong after pop");
`endif

endmodule

/* design/seven_segment_string_driver.sv */
// Seven-segment string driver: takes one message character per cycle and returns digits
// (position, segment mask with bit 0 = A, decimal point, last flag) for a DIGIT_COUNT-wide
// display. A character is accepted every cycle while the four-word output queue has two
// free slots; a character yields zero, one or two digits, and the output side drains one
// digit per cycle, so the sustained rate is one character per cycle unless results pile up.
// A digit is ready in the cycle after the character that settles it (its trailing dot,
// the next character, a zero byte or end of message) is accepted.
// Depends on sssd_pkg, sssd_front and sssd_queue.
module seven_segment_string_driver import sssd_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  push_t push;
  logic  space_ok;

  assign in_ready = space_ok;

  sssd_front #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .space_ok(space_ok),
    .in_word (in_word),
    .push    (push)
  );

  sssd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space_ok (space_ok),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

endmodule
